// File: hdl/rrle_pkg.sv
// Package for the row run-length encoder: defaults, reset values and helpers.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package rrle_pkg;

	// default configuration of the block
	localparam int MAX_COLS_DEF   = 4096;
	localparam int LEVEL_BITS_DEF = 8;
	localparam int ROW_BITS_DEF   = 16;

	// row width after reset, before clamping
	localparam int ROW_WIDTH_RST  = 1024;

	// result buffer depth; it must hold the two results of the item in
	// flight plus the two of the item just accepted
	localparam int RES_DEPTH      = 8;

	// number of results one item can cause
	localparam int MAX_PUSH       = 2;

	// row width reset value once clamped to the column limit
	function automatic int eff_width_rst(input int max_cols);
		int w;
		w = ROW_WIDTH_RST;
		if (w > max_cols) begin
			w = max_cols;
		end
		return w;
	endfunction

endpackage

// File: hdl/rrle_run_tracker.sv
// Run tracker: input register stage, row width register, column/row state
// and the single-pass run detection that forms up to two results per item.
// Depends on rrle_pkg.
`timescale 1ns / 1ps

module rrle_run_tracker #(
	parameter int MAX_COLS   = rrle_pkg::MAX_COLS_DEF,
	parameter int LEVEL_BITS = rrle_pkg::LEVEL_BITS_DEF,
	parameter int ROW_BITS   = rrle_pkg::ROW_BITS_DEF,
	parameter int COL_W      = $clog2(MAX_COLS),
	parameter int LEN_W      = COL_W + 1,
	parameter int RES_W      = ROW_BITS + COL_W + LEN_W + LEVEL_BITS + 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [LEVEL_BITS-1:0] level,
	input  logic                  frame_start,
	input  logic                  row_width_we,
	input  logic [LEN_W-1:0]      row_width,
	output logic [1:0]            push_cnt,
	output logic [RES_W-1:0]      res0,
	output logic [RES_W-1:0]      res1
);

	localparam int EFF_RST = rrle_pkg::eff_width_rst(MAX_COLS);

	// input stage
	logic                  valid_s1;
	logic [LEVEL_BITS-1:0] level_s1;
	logic                  frame_s1;

	// state
	logic [LEN_W-1:0]      width_q;
	logic [COL_W-1:0]      col_q;
	logic [COL_W-1:0]      start_q;
	logic [LEVEL_BITS-1:0] run_lvl_q;
	logic [ROW_BITS-1:0]   row_q;

	// next-state and result terms
	logic [COL_W-1:0]      col;
	logic [ROW_BITS-1:0]   row;
	logic [COL_W-1:0]      start;
	logic [LEVEL_BITS-1:0] run_lvl;
	logic                  emit_a;
	logic                  row_end;
	logic [LEN_W-1:0]      col_p1;
	logic [LEN_W-1:0]      len_a;
	logic [LEN_W-1:0]      len_b;
	logic [RES_W-1:0]      res_a;
	logic [RES_W-1:0]      res_b;
	logic [LEN_W-1:0]      width_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			level_s1 <= level;
			frame_s1 <= frame_start;
		end
	end

	// clamp the row width into 1..MAX_COLS when it is written
	always_comb begin
		width_eff = row_width;
		if (row_width == '0) begin
			width_eff = LEN_W'(1);
		end else if (row_width > LEN_W'(MAX_COLS)) begin
			width_eff = LEN_W'(MAX_COLS);
		end
	end

	always_comb begin
		col     = frame_s1 ? '0 : col_q;
		row     = frame_s1 ? '0 : row_q;
		emit_a  = 1'b0;
		start   = start_q;
		run_lvl = run_lvl_q;
		if (col == '0) begin
			start   = '0;
			run_lvl = level_s1;
		end else if (level_s1 != run_lvl_q) begin
			emit_a  = 1'b1;
			start   = col;
			run_lvl = level_s1;
		end
		col_p1  = {1'b0, col} + LEN_W'(1);
		row_end = (col_p1 >= width_q);
		len_a   = {1'b0, col} - {1'b0, start_q};
		len_b   = col_p1 - {1'b0, start};
		res_a   = {row, start_q, len_a, run_lvl_q, !row_end};
		res_b   = {row, start, len_b, run_lvl, 1'b1};
	end

	// compact the results so the first present one sits in slot 0
	always_comb begin
		push_cnt = 2'd0;
		res0     = res_a;
		res1     = res_b;
		if (valid_s1) begin
			push_cnt = 2'(emit_a) + 2'(row_end);
			if (!emit_a) begin
				res0 = res_b;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= LEN_W'(EFF_RST);
			col_q     <= '0;
			start_q   <= '0;
			run_lvl_q <= '0;
			row_q     <= '0;
		end else begin
			if (row_width_we) begin
				width_q <= width_eff;
			end
			if (valid_s1) begin
				run_lvl_q <= run_lvl;
				if (row_end) begin
					col_q   <= '0;
					start_q <= '0;
					row_q   <= row + ROW_BITS'(1);
				end else begin
					col_q   <= col_p1[COL_W-1:0];
					start_q <= start;
					row_q   <= row;
				end
			end
		end
	end

endmodule

// File: hdl/rrle_res_fifo.sv
// Result buffer: small register FIFO that takes up to two results a cycle
// and hands out one a cycle. Depends on rrle_pkg.
`timescale 1ns / 1ps

module rrle_res_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = rrle_pkg::RES_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [1:0]       push_cnt,
	input  logic [WIDTH-1:0] din0,
	input  logic [WIDTH-1:0] din1,
	input  logic             pop,
	output logic             not_empty,
	output logic             room,
	output logic [WIDTH-1:0] dout
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = PTR_W + 1;
	localparam int ROOM_MAX = DEPTH - 2 * rrle_pkg::MAX_PUSH;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic             do_pop;

	assign not_empty = (fill_q != '0);
	assign do_pop    = pop && not_empty;
	// room for the item in the input stage and one more behind it
	assign room      = (fill_q <= CNT_W'(ROOM_MAX));
	assign dout      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= din0;
		end
		if (push_cnt == 2'd2) begin
			mem_q[wr_ptr_q + PTR_W'(1)] <= din1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_cnt);
			rd_ptr_q <= rd_ptr_q + PTR_W'(do_pop);
			fill_q   <= fill_q + CNT_W'(push_cnt) - CNT_W'(do_pop);
		end
	end

endmodule

// File: hdl/row_run_length_encoder_core.sv
// Row run-length encoder. Raster levels enter one per cycle in row-major order;
// each run of equal levels inside a row leaves as one result (row, start
// column, length, level), and the end of a row closes the open run, so one
// item may cause two results, the second flagged by last_of_item. An item is
// registered, then classified in one pass against the column/run state, and its
// results go into an eight-entry buffer that drains one result per cycle while
// out_ready is high. The block takes one item per cycle while the buffer holds
// four results or fewer; the buffer's one-per-cycle drain sets the sustained
// rate when items cause two results. A frame_start item begins row 0, column 0
// and drops an unfinished run. Write row_width only while idle; 0 acts as 1 and
// values above MAX_COLS act as MAX_COLS.
// Depends on rrle_pkg, rrle_run_tracker and rrle_res_fifo.
`timescale 1ns / 1ps

module row_run_length_encoder_core #(
	parameter int MAX_COLS   = rrle_pkg::MAX_COLS_DEF,
	parameter int LEVEL_BITS = rrle_pkg::LEVEL_BITS_DEF,
	parameter int ROW_BITS   = rrle_pkg::ROW_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         row_width_we,
	input  logic [$clog2(MAX_COLS):0]    row_width,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [LEVEL_BITS-1:0]        level,
	input  logic                         frame_start,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ROW_BITS-1:0]          row_index,
	output logic [$clog2(MAX_COLS)-1:0]  run_start,
	output logic [$clog2(MAX_COLS):0]    run_length,
	output logic [LEVEL_BITS-1:0]        run_level,
	output logic                         last_of_item
);

	localparam int COL_W = $clog2(MAX_COLS);
	localparam int LEN_W = COL_W + 1;
	localparam int RES_W = ROW_BITS + COL_W + LEN_W + LEVEL_BITS + 1;

	logic [1:0]       push_cnt;
	logic [RES_W-1:0] res0;
	logic [RES_W-1:0] res1;
	logic [RES_W-1:0] head;

	rrle_run_tracker #(
		.MAX_COLS   (MAX_COLS),
		.LEVEL_BITS (LEVEL_BITS),
		.ROW_BITS   (ROW_BITS),
		.COL_W      (COL_W),
		.LEN_W      (LEN_W),
		.RES_W      (RES_W)
	) u_tracker (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (in_valid && in_ready),
		.level        (level),
		.frame_start  (frame_start),
		.row_width_we (row_width_we),
		.row_width    (row_width),
		.push_cnt     (push_cnt),
		.res0         (res0),
		.res1         (res1)
	);

	rrle_res_fifo #(
		.WIDTH (RES_W),
		.DEPTH (rrle_pkg::RES_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (push_cnt),
		.din0      (res0),
		.din1      (res1),
		.pop       (out_ready),
		.not_empty (out_valid),
		.room      (in_ready),
		.dout      (head)
	);

	assign {row_index, run_start, run_length, run_level, last_of_item} = head;

endmodule

// File: hdl/rrle_checker.sv
// Port-level checker for the row run-length encoder, bound to the top level.
// Depends on rrle_pkg and row_run_length_encoder_core.
`timescale 1ns / 1ps

module rrle_checker #(
	parameter int MAX_COLS   = rrle_pkg::MAX_COLS_DEF,
	parameter int LEVEL_BITS = rrle_pkg::LEVEL_BITS_DEF,
	parameter int ROW_BITS   = rrle_pkg::ROW_BITS_DEF
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [ROW_BITS-1:0]         row_index,
	input logic [$clog2(MAX_COLS)-1:0] run_start,
	input logic [$clog2(MAX_COLS):0]   run_length,
	input logic [LEVEL_BITS-1:0]       run_level,
	input logic                        last_of_item
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(row_index) &&
			$stable(run_start) && $stable(run_length) && $stable(run_level) &&
			$stable(last_of_item))
		else $error("stalled result changed");

	// a run is never empty
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> run_length != '0)
		else $error("zero run length");

	// the second result of an item is already buffered behind the first
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_item |=> out_valid)
		else $error("second result of item missing");

	// results only appear from an accepted item, via input register and buffer
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without an item");

	// input stalls only when results are backed up
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty buffer");

endmodule

bind row_run_length_encoder_core rrle_checker #(
	.MAX_COLS   (MAX_COLS),
	.LEVEL_BITS (LEVEL_BITS),
	.ROW_BITS   (ROW_BITS)
) u_rrle_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.row_index    (row_index),
	.run_start    (run_start),
	.run_length   (run_length),
	.run_level    (run_level),
	.last_of_item (last_of_item)
);
